// ----- design/lsf_pkg.sv -----
// Shared types and constants for the line substring filter.
package lsf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_WORDS   = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned LEN_REG_W   = 6;
  localparam int unsigned LINE_W      = 32;

  localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_INVERT    = 3'd5,
    REG_NUMBER    = 3'd6
  } cfg_index_t;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

endpackage

// ----- design/lsf_matcher.sv -----
// Window compare: pattern of the active length against the newest bytes.
module lsf_matcher #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] window,
  input  logic [PATTERN_MAX-1:0][7:0] pattern,
  input  logic [LEN_W-1:0]            len,
  input  logic [LEN_W-1:0]            seen,
  output logic                        hit
);
  import lsf_pkg::*;

  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [PATTERN_MAX-1:0] eq;

  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = len - LEN_W'(j) - LEN_W'(1);
      if (LEN_W'(j) < len) begin
        eq[j] = (window[j] == pattern[idx[IDX_W-1:0]]);
      end else begin
        eq[j] = 1'b1;
      end
    end
    hit = (len == '0) || ((seen >= len) && (&eq));
  end

endmodule

// ----- design/line_substring_filter.sv -----
// Top level of the fixed-string line filter.
//
// The block takes one text byte per cycle and gives one result per closed line
// (newline, or the byte marked end_of_input). An accepted byte is held in
// the input register, then the window compare (one byte comparator per
// window position, fed by a pattern byte mux) updates the line state and the
// result register; a result is valid once its closing byte has passed the
// input register and then the result register. The sustained rate is one
// byte per cycle; it drops only while a waiting result is not taken.
module line_substring_filter #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_input,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          line_selected,
  output logic [31:0]                   line_number,
  output logic                          show_number,
  input  logic                          cfg_we,
  input  logic [lsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsf_pkg::*;

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  cfg_word_t [CFG_WORDS-1:0] pattern_words;
  logic [LEN_REG_W-1:0]      pattern_length;
  logic                      invert_match;
  logic                      number_lines;

  logic                      s1_valid;
  logic [BYTE_W-1:0]         s1_byte;
  logic                      s1_last;

  logic [PATTERN_MAX-1:0][7:0] window;
  logic [PATTERN_MAX-1:0][7:0] window_next;
  logic [PATTERN_MAX-1:0][7:0] pattern;
  logic [LEN_W-1:0]            seen;
  logic [LEN_W-1:0]            seen_next;
  logic [LEN_W-1:0]            len;
  logic                        found;
  logic                        found_now;
  logic [LINE_W-1:0]           current_line;

  logic s1_nl;
  logic s1_emit;
  logic s1_advance;
  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      pattern_length <= '0;
      invert_match   <= 1'b0;
      number_lines   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_0_7:   pattern_words[0] <= cfg_data;
        REG_PAT_8_15:  pattern_words[1] <= cfg_data;
        REG_PAT_16_23: pattern_words[2] <= cfg_data;
        REG_PAT_24_31: pattern_words[3] <= cfg_data;
        REG_PAT_LEN:   pattern_length   <= cfg_data[LEN_REG_W-1:0];
        REG_INVERT:    invert_match     <= cfg_data[0];
        REG_NUMBER:    number_lines     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [CFG_WORDS*CFG_DATA_W-1:0] flat;
    flat    = pattern_words;
    pattern = flat[PATTERN_MAX*8-1:0];
  end

  always_comb begin
    if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = pattern_length[LEN_W-1:0];
    end
  end

  assign s1_nl      = (s1_byte == NEWLINE);
  assign s1_emit    = s1_nl || s1_last;
  assign s1_advance = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_comb begin
    window_next[0] = s1_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_next[i] = window[i-1];
    end
    seen_next = (seen < LEN_W'(PATTERN_MAX)) ? seen + LEN_W'(1) : seen;
  end

  lsf_matcher #(
    .PATTERN_MAX(PATTERN_MAX),
    .LEN_W      (LEN_W)
  ) u_matcher (
    .window (window_next),
    .pattern(pattern),
    .len    (len),
    .seen   (seen_next),
    .hit    (hit)
  );

  assign found_now = found || (!s1_nl && hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= text_byte;
      s1_last <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      seen         <= '0;
      found        <= 1'b0;
      current_line <= LINE_W'(1);
    end else if (s1_advance) begin
      if (!s1_nl) begin
        window <= window_next;
      end
      if (s1_emit) begin
        seen  <= '0;
        found <= 1'b0;
        if (current_line != LINE_MAX) begin
          current_line <= current_line + LINE_W'(1);
        end
      end else begin
        seen  <= seen_next;
        found <= found_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      line_selected <= ((len == '0) || found_now) ^ invert_match;
      line_number   <= current_line;
      show_number   <= number_lines;
    end
  end

endmodule

// ----- design/lsf_checker.sv -----
// Port-level checks for the line substring filter, bound to the top level.
module lsf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        line_selected,
  input logic [31:0] line_number,
  input logic        show_number
);
  import lsf_pkg::*;

  logic [LINE_W-1:0] exp_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_line <= LINE_W'(1);
    end else if (out_valid && out_ready && exp_line != LINE_MAX) begin
      exp_line <= exp_line + LINE_W'(1);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_number)
      && $stable(line_selected) && $stable(show_number))
    else $error("result changed while stalled");

  a_numbering: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number == exp_line)
    else $error("line number does not follow the count of results");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != '0)
    else $error("line number zero");

  a_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not empty after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (.*);
